// ===== design/stl_pkg.sv =====
// Shared types, token codes and keyword table for the script token lexer.
package stl_pkg;

  localparam int TYPE_W   = 6;
  localparam int OFF_W    = 24;
  localparam int LINE_W   = 20;
  localparam int SAT_W    = 32;

  // Token codes.
  localparam logic [TYPE_W-1:0] T_LPAREN  = 6'd0;
  localparam logic [TYPE_W-1:0] T_RPAREN  = 6'd1;
  localparam logic [TYPE_W-1:0] T_LBRACE  = 6'd2;
  localparam logic [TYPE_W-1:0] T_RBRACE  = 6'd3;
  localparam logic [TYPE_W-1:0] T_COMMA   = 6'd4;
  localparam logic [TYPE_W-1:0] T_DOT     = 6'd5;
  localparam logic [TYPE_W-1:0] T_MINUS   = 6'd6;
  localparam logic [TYPE_W-1:0] T_PLUS    = 6'd7;
  localparam logic [TYPE_W-1:0] T_SEMI    = 6'd8;
  localparam logic [TYPE_W-1:0] T_SLASH   = 6'd9;
  localparam logic [TYPE_W-1:0] T_STAR    = 6'd10;
  localparam logic [TYPE_W-1:0] T_QUEST   = 6'd11;
  localparam logic [TYPE_W-1:0] T_COLON   = 6'd12;
  localparam logic [TYPE_W-1:0] T_BANG    = 6'd13;
  localparam logic [TYPE_W-1:0] T_EQUAL   = 6'd15;
  localparam logic [TYPE_W-1:0] T_GREATER = 6'd17;
  localparam logic [TYPE_W-1:0] T_LESS    = 6'd19;
  localparam logic [TYPE_W-1:0] T_IDENT   = 6'd21;
  localparam logic [TYPE_W-1:0] T_STRING  = 6'd22;
  localparam logic [TYPE_W-1:0] T_NUMBER  = 6'd23;
  localparam logic [TYPE_W-1:0] T_EOF     = 6'd40;
  localparam logic [TYPE_W-1:0] T_BADCHAR = 6'd41;
  localparam logic [TYPE_W-1:0] T_BADSTR  = 6'd42;
  localparam logic [TYPE_W-1:0] T_BADCMT  = 6'd43;

  // Character codes.
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_LBRACE = 8'h7B;
  localparam logic [7:0] C_RBRACE = 8'h7D;
  localparam logic [7:0] C_COMMA  = 8'h2C;
  localparam logic [7:0] C_DOT    = 8'h2E;
  localparam logic [7:0] C_MINUS  = 8'h2D;
  localparam logic [7:0] C_PLUS   = 8'h2B;
  localparam logic [7:0] C_SEMI   = 8'h3B;
  localparam logic [7:0] C_STAR   = 8'h2A;
  localparam logic [7:0] C_QUEST  = 8'h3F;
  localparam logic [7:0] C_COLON  = 8'h3A;
  localparam logic [7:0] C_BANG   = 8'h21;
  localparam logic [7:0] C_EQUAL  = 8'h3D;
  localparam logic [7:0] C_GT     = 8'h3E;
  localparam logic [7:0] C_LT     = 8'h3C;
  localparam logic [7:0] C_SLASH  = 8'h2F;
  localparam logic [7:0] C_QUOTE  = 8'h22;
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_CR     = 8'h0D;
  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_NL     = 8'h0A;

  localparam int KW_N = 17;

  typedef struct packed {
    logic [TYPE_W-1:0] token_type;
    logic [OFF_W-1:0]  start_offset;
    logic [OFF_W-1:0]  lexeme_length;
    logic [LINE_W-1:0] line_number;
    logic              last;
  } tok_t;

  // All the tokens caused by one input word.
  typedef struct packed {
    logic [1:0]   n;
    tok_t [2:0]   tok;
  } grp_t;

  localparam logic [47:0] KW_TXT [KW_N] = '{
    48'("and"), 48'("class"), 48'("else"), 48'("false"), 48'("for"),
    48'("fun"), 48'("if"), 48'("nil"), 48'("or"), 48'("print"),
    48'("return"), 48'("super"), 48'("this"), 48'("true"), 48'("var"),
    48'("while"), 48'("break")};
  localparam logic [2:0] KW_LEN [KW_N] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd5,
    3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5};
  localparam logic [TYPE_W-1:0] KW_CODE [KW_N] = '{
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
    6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd44};

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  // Keyword compare; the buffer holds the first character in its low byte,
  // the table text holds it in the highest used byte.
  function automatic logic [TYPE_W-1:0] kw_code(input logic [47:0] wbuf,
                                                 input logic [2:0] wlen);
    logic [TYPE_W-1:0] code;
    logic              same;
    code = T_IDENT;
    for (int k = KW_N - 1; k >= 0; k--) begin
      same = (wlen == KW_LEN[k]);
      for (int i = 0; i < 6; i++) begin
        if (i < int'(KW_LEN[k]) &&
            wbuf[8*i +: 8] != KW_TXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        code = KW_CODE[k];
      end
    end
    return code;
  endfunction

endpackage

// ===== design/stl_src_if.sv =====
// Source channel: one source byte or the end marker per word.
interface stl_src_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] source_byte;

  modport source (output valid, kind, source_byte, input ready);
  modport sink (input valid, kind, source_byte, output ready);
endinterface

// ===== design/stl_tok_if.sv =====
// Token channel: one token per word.
interface stl_tok_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_type;
  logic [23:0] start_offset;
  logic [23:0] lexeme_length;
  logic [19:0] line_number;
  logic        last;

  modport source (output valid, token_type, start_offset, lexeme_length, line_number,
                  last, input ready);
  modport sink (input valid, token_type, start_offset, lexeme_length, line_number,
                last, output ready);
endinterface

// ===== design/stl_scan.sv =====
// Scanner state and the per-byte transition that builds up to three tokens.
module stl_scan #(
  parameter int OFFSET_BITS       = 24,
  parameter int LINE_BITS         = 20,
  parameter int MAX_COMMENT_DEPTH = 15
) (
  input  logic          clk,
  input  logic          rst,
  stl_src_if.sink       src,
  output logic          grp_valid,
  output stl_pkg::grp_t grp,
  input  logic          grp_ready
);
  import stl_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [SAT_W-1:0] OFF_FMAX  = SAT_W'({OFF_W{1'b1}});
  localparam logic [SAT_W-1:0] LINE_FMAX = SAT_W'({LINE_W{1'b1}});

  typedef enum logic [3:0] {
    M_IDLE, M_BANG, M_EQ, M_GT, M_LT, M_SLASH, M_LINECMT, M_BLK, M_BLK_SLASH,
    M_BLK_STAR, M_STR, M_INT, M_DOT, M_FRAC, M_WORD
  } mode_t;

  mode_t                    mode, mode_next;
  logic [OFFSET_BITS-1:0]   pos, pos_next;
  logic [OFFSET_BITS-1:0]   tstart, tstart_next;
  logic [LINE_BITS-1:0]     line, line_next;
  logic [47:0]              wbuf, wbuf_next;
  logic [2:0]               wlen, wlen_next;
  logic [DEPTH_W-1:0]       depth, depth_next;

  logic                     accept;
  logic [7:0]               c;
  logic [OFFSET_BITS-1:0]   nxt, dpos;
  logic [1:0]               n;
  tok_t [2:0]               toks;
  logic                     fresh;
  logic [LINE_W-1:0]        line_sat;

  function automatic logic [OFF_W-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
    logic [SAT_W-1:0] e;
    e = SAT_W'(v);
    return (e > OFF_FMAX) ? {OFF_W{1'b1}} : e[OFF_W-1:0];
  endfunction

  function automatic tok_t mk(input logic [TYPE_W-1:0] t,
                              input logic [OFFSET_BITS-1:0] s,
                              input logic [OFFSET_BITS-1:0] l,
                              input logic [LINE_W-1:0] ln, input logic lst);
    tok_t r;
    r.token_type    = t;
    r.start_offset  = sat_off(s);
    r.lexeme_length = sat_off(l);
    r.line_number   = ln;
    r.last          = lst;
    return r;
  endfunction

  function automatic logic [TYPE_W-1:0] op_single(input mode_t m);
    logic [TYPE_W-1:0] t;
    case (m)
      M_BANG:  t = T_BANG;
      M_EQ:    t = T_EQUAL;
      M_GT:    t = T_GREATER;
      default: t = T_LESS;
    endcase
    return t;
  endfunction

  assign accept    = src.valid && src.ready;
  assign src.ready = grp_ready;
  assign c         = src.source_byte;
  assign nxt       = (pos == OFF_MAX) ? pos : pos + 1'b1;
  assign dpos      = (pos > tstart) ? pos - 1'b1 : pos;
  assign line_sat  = (SAT_W'(line) > LINE_FMAX) ? {LINE_W{1'b1}} : LINE_W'(line);

  // Per-word transition: every token of one word carries the line count it
  // found on entry.
  always_comb begin
    mode_next   = mode;
    pos_next    = nxt;
    tstart_next = tstart;
    line_next   = line;
    wbuf_next   = wbuf;
    wlen_next   = wlen;
    depth_next  = depth;
    n           = 2'd0;
    toks        = '0;
    fresh       = 1'b0;

    if (src.kind) begin
      // End marker flushes any pending token, then closes with EOF.
      case (mode)
        M_BANG, M_EQ, M_GT, M_LT: begin
          toks[n] = mk(op_single(mode), tstart, pos - tstart, line_sat, 1'b0);
          n = n + 1'b1;
        end
        M_SLASH: begin
          toks[n] = mk(T_SLASH, tstart, pos - tstart, line_sat, 1'b0);
          n = n + 1'b1;
        end
        M_BLK, M_BLK_SLASH, M_BLK_STAR: begin
          toks[n] = mk(T_BADCMT, tstart, pos - tstart, line_sat, 1'b0);
          n = n + 1'b1;
        end
        M_STR: begin
          toks[n] = mk(T_BADSTR, tstart, pos - tstart, line_sat, 1'b0);
          n = n + 1'b1;
        end
        M_INT, M_FRAC: begin
          toks[n] = mk(T_NUMBER, tstart, pos - tstart, line_sat, 1'b0);
          n = n + 1'b1;
        end
        M_DOT: begin
          toks[n] = mk(T_NUMBER, tstart, dpos - tstart, line_sat, 1'b0);
          n = n + 1'b1;
          toks[n] = mk(T_DOT, dpos, OFFSET_BITS'(1), line_sat, 1'b0);
          n = n + 1'b1;
        end
        M_WORD: begin
          toks[n] = mk(kw_code(wbuf, wlen), tstart, pos - tstart, line_sat, 1'b0);
          n = n + 1'b1;
        end
        default: ;
      endcase
      toks[n] = mk(T_EOF, pos, '0, line_sat, 1'b1);
      n = n + 1'b1;
      mode_next   = M_IDLE;
      pos_next    = '0;
      tstart_next = '0;
      line_next   = LINE_BITS'(1);
      wbuf_next   = '0;
      wlen_next   = '0;
      depth_next  = '0;
    end else begin
      case (mode)
        M_BANG, M_EQ, M_GT, M_LT: begin
          mode_next = M_IDLE;
          if (c == C_EQUAL) begin
            toks[n] = mk(op_single(mode) + 1'b1, tstart, nxt - tstart, line_sat, 1'b0);
            n = n + 1'b1;
          end else begin
            toks[n] = mk(op_single(mode), tstart, pos - tstart, line_sat, 1'b0);
            n = n + 1'b1;
            fresh = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == C_SLASH) begin
            mode_next = M_LINECMT;
          end else if (c == C_STAR) begin
            mode_next  = M_BLK;
            depth_next = DEPTH_W'(1);
          end else begin
            mode_next = M_IDLE;
            toks[n] = mk(T_SLASH, tstart, pos - tstart, line_sat, 1'b0);
            n = n + 1'b1;
            fresh = 1'b1;
          end
        end
        M_LINECMT: begin
          if (c == C_NL) begin
            mode_next = M_IDLE;
            if (line != LINE_MAX) line_next = line + 1'b1;
          end
        end
        M_BLK, M_BLK_SLASH, M_BLK_STAR: begin
          if (mode == M_BLK_SLASH && c == C_STAR) begin
            // Nested opening.
            if (depth < DEPTH_W'(MAX_COMMENT_DEPTH)) depth_next = depth + 1'b1;
            mode_next = M_BLK;
          end else if (mode == M_BLK_STAR && c == C_SLASH) begin
            // Closing pair ends one level.
            depth_next = (depth != '0) ? depth - 1'b1 : depth;
            mode_next  = (depth_next == '0) ? M_IDLE : M_BLK;
          end else if (c == C_NL) begin
            if (line != LINE_MAX) line_next = line + 1'b1;
            mode_next = M_BLK;
          end else if (c == C_SLASH) begin
            mode_next = M_BLK_SLASH;
          end else if (c == C_STAR) begin
            mode_next = M_BLK_STAR;
          end else begin
            mode_next = M_BLK;
          end
        end
        M_STR: begin
          if (c == C_QUOTE) begin
            toks[n] = mk(T_STRING, tstart, nxt - tstart, line_sat, 1'b0);
            n = n + 1'b1;
            mode_next = M_IDLE;
          end else if (c == C_NL) begin
            if (line != LINE_MAX) line_next = line + 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (mode == M_INT && c == C_DOT) begin
            mode_next = M_DOT;
          end else if (!is_digit(c)) begin
            toks[n] = mk(T_NUMBER, tstart, pos - tstart, line_sat, 1'b0);
            n = n + 1'b1;
            mode_next = M_IDLE;
            fresh = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            mode_next = M_FRAC;
          end else begin
            toks[n] = mk(T_NUMBER, tstart, dpos - tstart, line_sat, 1'b0);
            n = n + 1'b1;
            toks[n] = mk(T_DOT, dpos, OFFSET_BITS'(1), line_sat, 1'b0);
            n = n + 1'b1;
            mode_next = M_IDLE;
            fresh = 1'b1;
          end
        end
        M_WORD: begin
          if (is_digit(c) || is_alpha(c)) begin
            if (wlen < 3'd6) begin
              wbuf_next[8*wlen +: 8] = c;
              wlen_next = wlen + 1'b1;
            end else begin
              wlen_next = 3'd7;
            end
          end else begin
            toks[n] = mk(kw_code(wbuf, wlen), tstart, pos - tstart, line_sat, 1'b0);
            n = n + 1'b1;
            mode_next = M_IDLE;
            fresh = 1'b1;
          end
        end
        default: begin
          mode_next = M_IDLE;
          fresh = 1'b1;
        end
      endcase

      // The byte opens a new lexeme.
      if (fresh) begin
        tstart_next = pos;
        case (c)
          C_LPAREN: begin toks[n] = mk(T_LPAREN, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_RPAREN: begin toks[n] = mk(T_RPAREN, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_LBRACE: begin toks[n] = mk(T_LBRACE, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_RBRACE: begin toks[n] = mk(T_RBRACE, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_COMMA:  begin toks[n] = mk(T_COMMA, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_DOT:    begin toks[n] = mk(T_DOT, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_MINUS:  begin toks[n] = mk(T_MINUS, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_PLUS:   begin toks[n] = mk(T_PLUS, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_SEMI:   begin toks[n] = mk(T_SEMI, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_STAR:   begin toks[n] = mk(T_STAR, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_QUEST:  begin toks[n] = mk(T_QUEST, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_COLON:  begin toks[n] = mk(T_COLON, pos, OFFSET_BITS'(1), line_sat, 1'b0);
                          n = n + 1'b1; end
          C_BANG:   mode_next = M_BANG;
          C_EQUAL:  mode_next = M_EQ;
          C_GT:     mode_next = M_GT;
          C_LT:     mode_next = M_LT;
          C_SLASH:  mode_next = M_SLASH;
          C_QUOTE:  mode_next = M_STR;
          C_SPACE, C_CR, C_TAB: ;
          C_NL: begin
            if (line != LINE_MAX) line_next = line + 1'b1;
          end
          default: begin
            if (is_digit(c)) begin
              mode_next = M_INT;
            end else if (is_alpha(c)) begin
              mode_next = M_WORD;
              wbuf_next = {40'd0, c};
              wlen_next = 3'd1;
            end else begin
              toks[n] = mk(T_BADCHAR, pos, OFFSET_BITS'(1), line_sat, 1'b0);
              n = n + 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign grp_valid = accept && (n != 2'd0);
  assign grp.n     = n;
  assign grp.tok   = toks;

  // Scanner state advances on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      tstart <= '0;
      line   <= LINE_BITS'(1);
      wbuf   <= '0;
      wlen   <= '0;
      depth  <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      line   <= line_next;
      wbuf   <= wbuf_next;
      wlen   <= wlen_next;
      depth  <= depth_next;
    end
  end

  // An end marker always leaves the scanner at the start of a new stream.
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    accept && src.kind |=> mode == M_IDLE && pos == '0 && line == LINE_BITS'(1))
    else $error("scanner not reset after end marker");

  // The lexeme start never runs ahead of the byte position.
  a_start_le_pos: assert property (@(posedge clk) disable iff (rst) tstart <= pos)
    else $error("token start past byte position");

  // Inside a block comment the depth is never zero.
  a_depth_nz: assert property (@(posedge clk) disable iff (rst)
    (mode == M_BLK || mode == M_BLK_SLASH || mode == M_BLK_STAR) |-> depth != '0)
    else $error("block comment with zero depth");

endmodule

// ===== design/stl_out.sv =====
// Two-entry queue of token groups, drained one token per word.
module stl_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          grp_valid,
  input  stl_pkg::grp_t grp,
  output logic          grp_ready,
  stl_tok_if.source     tok
);
  import stl_pkg::*;

  grp_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic [1:0] sub;
  logic       push, pop, take;
  tok_t       cur;

  assign grp_ready = (cnt != 2'd2);
  assign push      = grp_valid && grp_ready;
  assign take      = tok.valid && tok.ready;
  assign pop       = take && (sub == q[rd_ptr].n - 1'b1);
  assign cur       = q[rd_ptr].tok[sub];

  assign tok.valid         = (cnt != 2'd0);
  assign tok.token_type    = cur.token_type;
  assign tok.start_offset  = cur.start_offset;
  assign tok.lexeme_length = cur.lexeme_length;
  assign tok.line_number   = cur.line_number;
  assign tok.last          = cur.last;

  // Group storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= grp;
    end
  end

  // Pointers, fill count and position inside the head group.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
      sub    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        sub    <= 2'd0;
      end else if (take) begin
        sub <= sub + 1'b1;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("group queue over capacity");

  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    tok.valid |-> sub < q[rd_ptr].n)
    else $error("token index past group size");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> grp.n != 2'd0)
    else $error("empty group queued");

endmodule

// ===== design/script_token_lexer_top.sv =====
// Top level of the streaming script token lexer.
//
//  channel  direction  word contents
//  src      in         kind, source_byte (one byte or the end marker)
//  tok      out        token_type, start_offset, lexeme_length, line_number, last
//
// One source word is taken per cycle while the group queue has room; the scanner state
// updates in the same cycle and the word's tokens (zero to three) enter a two-group queue.
// Tokens leave one per cycle while tok is ready, so a word's tokens leave in order, one by one.
// Synchronous active-high reset puts the scanner at offset 0, line 1.
// src stalls only when the group queue is full; tok backpressure holds the head token.
module script_token_lexer_top #(
  parameter int OFFSET_BITS       = 24,
  parameter int LINE_BITS         = 20,
  parameter int MAX_COMMENT_DEPTH = 15
) (
  input logic       clk,
  input logic       rst,
  stl_src_if.sink   src,
  stl_tok_if.source tok
);
  import stl_pkg::*;

  logic grp_valid;
  logic grp_ready;
  grp_t grp;

  // Per-byte scanner.
  stl_scan #(
    .OFFSET_BITS      (OFFSET_BITS),
    .LINE_BITS        (LINE_BITS),
    .MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .src      (src),
    .grp_valid(grp_valid),
    .grp      (grp),
    .grp_ready(grp_ready)
  );

  // Token queue and serializer.
  stl_out u_out (
    .clk      (clk),
    .rst      (rst),
    .grp_valid(grp_valid),
    .grp      (grp),
    .grp_ready(grp_ready),
    .tok      (tok)
  );

endmodule

// ===== dv/tb_script_token_lexer_top.sv =====
// Testbench for the script token lexer: directed and random byte streams checked against a predictor.
module tb_script_token_lexer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stl_pkg::*;

  localparam int MAX_DEPTH = 15;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_BANG, S_EQ, S_GT, S_LT, S_SLASH, S_LINECMT, S_BLK, S_BLK_SLASH,
    S_BLK_STAR, S_STR, S_INT, S_DOT, S_FRAC, S_WORD
  } scan_e;

  typedef struct {
    logic       kind;
    logic [7:0] ch;
  } src_word_t;

  logic clk;
  logic rst;
  stl_src_if src ();
  stl_tok_if tok ();

  script_token_lexer_top dut (.clk(clk), .rst(rst), .src(src.sink), .tok(tok.source));

  src_word_t pending_bytes[$];
  tok_t      expected_tokens[$];
  int        n_errors;
  int        n_tokens_seen;
  int        n_bytes_sent;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;
  bit        hold_go;
  bit        hold_done;

  // Predictor state.
  scan_e              sc_mode;
  logic [OFF_W-1:0]   sc_pos;
  logic [OFF_W-1:0]   sc_start;
  logic [LINE_W-1:0]  sc_line;
  logic [47:0]        sc_wbuf;
  logic [2:0]         sc_wlen;
  int                 sc_depth;

  // Keyword list kept in source order for lookup.
  string     kw_names[17] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                              "or", "print", "return", "super", "this", "true", "var",
                              "while", "break"};
  logic [5:0] kw_codes[17] = '{6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
                               6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
                               6'd44};

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    n_errors++;
  endtask

  function automatic bit digit_c(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  task automatic lexer_reset();
    sc_mode = S_IDLE;
    sc_pos = '0;
    sc_start = '0;
    sc_line = 1;
    sc_wbuf = '0;
    sc_wlen = '0;
    sc_depth = 0;
  endtask

  task automatic expect_token(input logic [5:0] ty, input logic [OFF_W-1:0] st,
                              input logic [OFF_W-1:0] len, input logic last);
    tok_t t;
    t.token_type = ty;
    t.start_offset = st;
    t.lexeme_length = len;
    t.line_number = sc_line;
    t.last = last;
    expected_tokens = {expected_tokens, t};
  endtask

  task automatic bump_line();
    if (sc_line != LINE_MAX) sc_line++;
  endtask

  function automatic logic [5:0] word_token_code();
    bit same;
    if (sc_wlen > 6) return T_IDENT;
    for (int k = 0; k < 17; k++) begin
      same = kw_names[k].len() == sc_wlen;
      for (int i = 0; same && i < sc_wlen; i++) begin
        if (sc_wbuf[8*i +: 8] != kw_names[k][i]) same = 0;
      end
      if (same) return kw_codes[k];
    end
    return T_IDENT;
  endfunction

  task automatic add_letter(input logic [7:0] c);
    if (sc_wlen < 6) begin
      sc_wbuf[8*sc_wlen +: 8] = c;
      sc_wlen++;
    end else begin
      sc_wlen = 7;
    end
  endtask

  function automatic logic [5:0] single_op(input scan_e m);
    case (m)
      S_BANG: return T_BANG;
      S_EQ: return T_EQUAL;
      S_GT: return T_GREATER;
      default: return T_LESS;
    endcase
  endfunction

  // A number whose dot had no digit after it splits into a number and a dot.
  task automatic flush_number_dot(input logic [OFF_W-1:0] dot_pos);
    logic [OFF_W-1:0] d;
    d = dot_pos > sc_start ? dot_pos - 1 : dot_pos;
    expect_token(T_NUMBER, sc_start, d - sc_start, 0);
    expect_token(T_DOT, d, 1, 0);
  endtask

  task automatic begin_token(input logic [7:0] c, input logic [OFF_W-1:0] cur);
    sc_start = cur;
    case (c)
      C_LPAREN: expect_token(T_LPAREN, cur, 1, 0);
      C_RPAREN: expect_token(T_RPAREN, cur, 1, 0);
      C_LBRACE: expect_token(T_LBRACE, cur, 1, 0);
      C_RBRACE: expect_token(T_RBRACE, cur, 1, 0);
      C_COMMA: expect_token(T_COMMA, cur, 1, 0);
      C_DOT: expect_token(T_DOT, cur, 1, 0);
      C_MINUS: expect_token(T_MINUS, cur, 1, 0);
      C_PLUS: expect_token(T_PLUS, cur, 1, 0);
      C_SEMI: expect_token(T_SEMI, cur, 1, 0);
      C_STAR: expect_token(T_STAR, cur, 1, 0);
      C_QUEST: expect_token(T_QUEST, cur, 1, 0);
      C_COLON: expect_token(T_COLON, cur, 1, 0);
      C_BANG: sc_mode = S_BANG;
      C_EQUAL: sc_mode = S_EQ;
      C_GT: sc_mode = S_GT;
      C_LT: sc_mode = S_LT;
      C_SLASH: sc_mode = S_SLASH;
      C_QUOTE: sc_mode = S_STR;
      C_SPACE, C_CR, C_TAB: ;
      C_NL: bump_line();
      default: begin
        if (digit_c(c)) begin
          sc_mode = S_INT;
        end else if (alpha_c(c)) begin
          sc_mode = S_WORD;
          sc_wbuf = '0;
          sc_wlen = '0;
          add_letter(c);
        end else begin
          expect_token(T_BADCHAR, cur, 1, 0);
        end
      end
    endcase
  endtask

  task automatic comment_char(input logic [7:0] c);
    if (c == C_NL) bump_line();
    else if (c == C_SLASH) sc_mode = S_BLK_SLASH;
    else if (c == C_STAR) sc_mode = S_BLK_STAR;
    else sc_mode = S_BLK;
  endtask

  // Predict the tokens caused by one accepted source word.
  task automatic predict_tokens(input src_word_t w);
    logic [OFF_W-1:0] cur, nxt;
    logic [7:0]       c;
    bit               fresh;
    cur = sc_pos;
    nxt = (cur == OFF_MAX) ? cur : cur + 1;
    c = w.ch;
    fresh = 0;
    if (w.kind) begin
      case (sc_mode)
        S_BANG, S_EQ, S_GT, S_LT: expect_token(single_op(sc_mode), sc_start, cur - sc_start, 0);
        S_SLASH: expect_token(T_SLASH, sc_start, cur - sc_start, 0);
        S_BLK, S_BLK_SLASH, S_BLK_STAR: expect_token(T_BADCMT, sc_start, cur - sc_start, 0);
        S_STR: expect_token(T_BADSTR, sc_start, cur - sc_start, 0);
        S_INT, S_FRAC: expect_token(T_NUMBER, sc_start, cur - sc_start, 0);
        S_DOT: flush_number_dot(cur);
        S_WORD: expect_token(word_token_code(), sc_start, cur - sc_start, 0);
        default: ;
      endcase
      expect_token(T_EOF, cur, 0, 1);
      lexer_reset();
      return;
    end
    case (sc_mode)
      S_BANG, S_EQ, S_GT, S_LT: begin
        if (c == C_EQUAL) begin
          expect_token(single_op(sc_mode) + 6'd1, sc_start, nxt - sc_start, 0);
        end else begin
          expect_token(single_op(sc_mode), sc_start, cur - sc_start, 0);
          fresh = 1;
        end
        sc_mode = S_IDLE;
      end
      S_SLASH: begin
        if (c == C_SLASH) begin
          sc_mode = S_LINECMT;
        end else if (c == C_STAR) begin
          sc_mode = S_BLK;
          sc_depth = 1;
        end else begin
          sc_mode = S_IDLE;
          expect_token(T_SLASH, sc_start, cur - sc_start, 0);
          fresh = 1;
        end
      end
      S_LINECMT: begin
        if (c == C_NL) begin
          bump_line();
          sc_mode = S_IDLE;
        end
      end
      S_BLK: comment_char(c);
      S_BLK_SLASH: begin
        if (c == C_STAR) begin
          if (sc_depth < MAX_DEPTH) sc_depth++;
          sc_mode = S_BLK;
        end else begin
          comment_char(c);
        end
      end
      S_BLK_STAR: begin
        if (c == C_SLASH) begin
          if (sc_depth > 0) sc_depth--;
          sc_mode = (sc_depth == 0) ? S_IDLE : S_BLK;
        end else begin
          comment_char(c);
        end
      end
      S_STR: begin
        if (c == C_QUOTE) begin
          expect_token(T_STRING, sc_start, nxt - sc_start, 0);
          sc_mode = S_IDLE;
        end else if (c == C_NL) begin
          bump_line();
        end
      end
      S_INT: begin
        if (c == C_DOT) begin
          sc_mode = S_DOT;
        end else if (!digit_c(c)) begin
          expect_token(T_NUMBER, sc_start, cur - sc_start, 0);
          sc_mode = S_IDLE;
          fresh = 1;
        end
      end
      S_DOT: begin
        if (digit_c(c)) begin
          sc_mode = S_FRAC;
        end else begin
          flush_number_dot(cur);
          sc_mode = S_IDLE;
          fresh = 1;
        end
      end
      S_FRAC: begin
        if (!digit_c(c)) begin
          expect_token(T_NUMBER, sc_start, cur - sc_start, 0);
          sc_mode = S_IDLE;
          fresh = 1;
        end
      end
      S_WORD: begin
        if (digit_c(c) || alpha_c(c)) begin
          add_letter(c);
        end else begin
          expect_token(word_token_code(), sc_start, cur - sc_start, 0);
          sc_mode = S_IDLE;
          fresh = 1;
        end
      end
      default: begin
        sc_mode = S_IDLE;
        fresh = 1;
      end
    endcase
    if (fresh) begin_token(c, cur);
    sc_pos = nxt;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    src_word_t w;
    w.kind = 0;
    w.ch = b;
    pending_bytes = {pending_bytes, w};
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i]);
    end
  endtask

  task automatic queue_end();
    src_word_t w;
    w.kind = 1;
    w.ch = 8'($urandom);
    pending_bytes = {pending_bytes, w};
  endtask

  // Random snippet of mostly well-formed source text.
  function automatic string random_fragment();
    string s;
    string ops[20] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*", "?", ":",
                       "!", "!=", "=", "==", ">", ">=", "<", "<="};
    s = "";
    case ($urandom_range(0, 11))
      0: s = kw_names[$urandom_range(0, 16)];
      1: begin
        s = "";
        repeat ($urandom_range(1, 9)) s = {s, string'(8'($urandom_range("a", "z")))};
      end
      2: s = $sformatf("%0d", $urandom_range(0, 9999));
      3: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
      4: s = $sformatf("%0d.", $urandom_range(0, 9));
      5: s = "\"str\nx\"";
      6: s = ops[$urandom_range(0, 19)];
      7: s = "// note\n";
      8: s = "/* a /* b */ c */";
      9: s = "\n";
      10: s = string'(8'($urandom));
      default: s = " ";
    endcase
    return s;
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: offers the next pending word, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      src.valid <= 0;
      src.kind <= 0;
      src.source_byte <= 0;
    end else begin
      if (src.valid && src.ready) begin
        predict_tokens('{kind: src.kind, ch: src.source_byte});
        n_bytes_sent++;
      end
      if (!src.valid || src.ready) begin
        if (src.valid && src.ready) void'(pending_bytes.pop_front());
        if (pending_bytes.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
          src.valid <= 1;
          src.kind <= pending_bytes[0].kind;
          src.source_byte <= pending_bytes[0].ch;
        end else begin
          src.valid <= 0;
        end
      end
    end
  end

  // Receiver stall generation, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      tok.ready <= 0;
      hold_cycles <= 0;
      hold_done <= 0;
    end else if (hold_go && !hold_done) begin
      hold_cycles <= 60;
      hold_done <= 1;
      tok.ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      tok.ready <= 0;
    end else begin
      tok.ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Monitor: compares each accepted token with the oldest expectation.
  always @(posedge clk) begin
    tok_t e;
    cycle_count++;
    if (!rst && tok.valid && tok.ready) begin
      n_tokens_seen++;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token type %0d", tok.token_type));
      end else begin
        e = expected_tokens.pop_front();
        if (tok.token_type !== e.token_type)
          report_mismatch($sformatf("type %0d, expected %0d", tok.token_type, e.token_type));
        if (tok.start_offset !== e.start_offset)
          report_mismatch($sformatf("start %0d, expected %0d", tok.start_offset,
                                    e.start_offset));
        if (tok.lexeme_length !== e.lexeme_length)
          report_mismatch($sformatf("length %0d, expected %0d", tok.lexeme_length,
                                    e.lexeme_length));
        if (tok.line_number !== e.line_number)
          report_mismatch($sformatf("line %0d, expected %0d", tok.line_number,
                                    e.line_number));
        if (tok.last !== e.last)
          report_mismatch($sformatf("last %0d, expected %0d", tok.last, e.last));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_bytes.size() > 0 || src.valid || expected_tokens.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(input int n_items, input int idle, input int stall);
    string s;
    int start_count;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    start_count = 0;
    while (start_count < n_items) begin
      s = random_fragment();
      queue_text(s);
      start_count += s.len();
      if ($urandom_range(0, 14) == 0) begin
        queue_end();
        start_count++;
      end
    end
    queue_end();
    drain();
  endtask

  initial begin
    n_errors = 0;
    n_tokens_seen = 0;
    n_bytes_sent = 0;
    cycle_count = 0;
    hold_go = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    lexer_reset();
    rst = 1;
    repeat (8) @(posedge clk);
    rst <= 0;

    // Directed: operators, keywords, numbers, comments, strings, odd bytes.
    queue_text("(){},.-+;*?:! != = == > >= < <= / x");
    queue_end();
    queue_text("and class else false for fun if nil or print return super this true");
    queue_text(" var while break breaks orx _A9zZ abcdefghij 7.5 12. 3.x");
    queue_end();
    queue_text("\"a\nb\" // c\n/* /* */ */ 1/*/**");
    queue_end();
    queue_text("\"open");
    queue_end();
    queue_text("4.");
    queue_end();
    queue_byte(8'h00);
    queue_text({8'hFF, 8'h80, 8'h7F, 8'h40, 8'h0D, 8'h09, "!"});
    queue_end();
    queue_end();
    drain();

    // Long receiver hold-off while the sender keeps offering words.
    hold_go = 1;
    random_phase(20, 0, 0);

    random_phase(30, 0, 0);
    random_phase(30, 77, 0);
    random_phase(30, 0, 77);
    random_phase(30, 34, 34);

    repeat (20) @(posedge clk);
    $display("Covered %0d source words and %0d tokens over operators, keywords, numbers,",
             n_bytes_sent, n_tokens_seen);
    $display("strings, nested comments, invalid bytes and end markers under stalls.");
    if (n_errors == 0 && expected_tokens.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/stl_pkg.sv
design/stl_src_if.sv
design/stl_tok_if.sv
design/stl_scan.sv
design/stl_out.sv
design/script_token_lexer_top.sv
dv/tb_script_token_lexer_top.sv
